FILE: src/wsi_pkg.sv
// Shared types and constants for the waypoint step interpolator.
// Used by the controller, datapath, divider, top level and checker; no dependencies.
package wsi_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
    localparam int COORD_W       = 32;
    localparam int STEPS_W       = 16;
    localparam int DIVIDEND_W    = COORD_W + 1;
    localparam int ITER_W        = $clog2(DIVIDEND_W + 1);
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_END = CFG_IDX_W'(1);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_STEP    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_ZERO_STEPS = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_SRC,
        S_RD_TGT,
        S_DIVIDE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_ZERO,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_RD,
        OUT_DELTA,
        OUT_DIV
    } t_out_sel;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ADVANCE,
        ACT_SEGMENT,
        ACT_RESTART
    } t_act;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [STEPS_W-1:0] steps;
    } t_wp;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     append;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     hold_src;
        logic     div_start;
        logic     div_by_one;
        logic     load_out;
        t_out_sel out_sel;
        t_status  out_status;
        t_act     act;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic need_seg;
        logic at_end;
        logic loop_en;
        logic connect;
        logic tgt_zero;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

FILE: src/waypoint_step_interpolator.sv
// Top level of the 3D waypoint step interpolator.
// Joins wsi_ctrl and wsi_datapath; depends on wsi_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: clear, append a
//   waypoint (Q16.16 x, y, z and a step count), restart at the first waypoint, or
//   step. Each request yields exactly one transfer on the output channel
//   (o_out_valid / i_out_ready): start point on restart, per-step delta on a
//   step, else zeros, with a status (ok, empty path, zero step count, table full).
//   Configuration (loop_enable, connect_end) must be written through i_cfg_we /
//   i_cfg_idx / i_cfg_data while the block is idle; the block does not enforce it.
// Sequencing (one request at a time)
//   Clear, append and requests on an empty path go straight to output; restart
//   and a step inside a segment read one waypoint; a step that enters a new
//   segment or jumps to the head also reads the target and waits for the one-bit
//   iterations of the three divider lanes, which run side by side. Table reads
//   use one registered read port, so source and target come on successive cycles.
// Reset and stalls
//   Reset empties the path, puts it at its first vertex and clears the deltas
//   and configuration; the waypoint table itself is not cleared. A result waits
//   in the output register while the receiver stalls; the next request is still
//   taken and worked on, and holds in its output state until the register frees.
module waypoint_step_interpolator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [wsi_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic                                  i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [wsi_pkg::REQ_W-1:0]             i_req_type,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_x,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_y,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_z,
    input  logic [wsi_pkg::STEPS_W-1:0]           i_in_steps,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_y,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_z,
    output logic [wsi_pkg::STATUS_W-1:0]          o_status
);

    // Commands run from controller to datapath, status flags back
    wsi_pkg::t_cmd  w_cmd;
    wsi_pkg::t_stat w_stat;

    wsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wsi_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_z      (i_in_z),
        .i_in_steps  (i_in_steps),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_status    (o_status)
    );

endmodule

FILE: src/wsi_div.sv
// Iterative signed divider: 33-bit dividend by 16-bit unsigned divisor, one bit a cycle.
// Truncates toward zero and saturates the quotient to 32 bits. Depends on wsi_pkg.
module wsi_div (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic signed [wsi_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic        [wsi_pkg::STEPS_W-1:0]       i_divisor,
    output logic                                     o_busy,
    output logic signed [wsi_pkg::COORD_W-1:0]       o_quot
);

    localparam int DW = wsi_pkg::DIVIDEND_W;
    localparam int SW = wsi_pkg::STEPS_W;
    localparam int CW = wsi_pkg::COORD_W;
    localparam logic [DW-1:0] MAG_MAX_POS = {2'b00, {(CW-1){1'b1}}};
    localparam logic [DW-1:0] MAG_MAX_NEG = {2'b01, {(CW-1){1'b0}}};

    logic                          r_busy;
    logic                          r_neg;
    logic [DW-1:0]                 r_q;
    logic [SW-1:0]                 r_rem;
    logic [SW-1:0]                 r_div;
    logic [wsi_pkg::ITER_W-1:0]    r_iter;

    logic [DW-1:0] w_mag;
    logic [SW:0]   w_shift;
    logic [SW:0]   w_sub;
    logic          w_ge;
    logic [DW-1:0] w_neg_q;

    assign w_mag   = i_dividend[DW-1] ? (~i_dividend + DW'(1)) : i_dividend;
    assign w_shift = {r_rem, r_q[DW-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_sub   = w_shift - {1'b0, r_div};
    assign w_neg_q = ~r_q + DW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_iter == wsi_pkg::ITER_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[DW-1];
            r_q    <= w_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_iter <= wsi_pkg::ITER_W'(DW);
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[SW-1:0] : w_shift[SW-1:0];
            r_q    <= {r_q[DW-2:0], w_ge};
            r_iter <= r_iter - wsi_pkg::ITER_W'(1);
        end
    end

    // Saturate the signed quotient to the coordinate range
    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > MAG_MAX_NEG) ? {1'b1, {(CW-1){1'b0}}} : w_neg_q[CW-1:0];
        end else begin
            o_quot = (r_q > MAG_MAX_POS) ? {1'b0, {(CW-1){1'b1}}} : r_q[CW-1:0];
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: src/wsi_datapath.sv
// Datapath: waypoint table, path state, three divider lanes and the result register.
// Driven by wsi_ctrl through t_cmd; depends on wsi_pkg and wsi_div.
module wsi_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wsi_pkg::t_cmd                         i_cmd,
    output wsi_pkg::t_stat                        o_stat,
    input  logic                                  i_cfg_we,
    input  logic [wsi_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic                                  i_cfg_data,
    input  logic [wsi_pkg::REQ_W-1:0]             i_req_type,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_x,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_y,
    input  logic signed [wsi_pkg::COORD_W-1:0]    i_in_z,
    input  logic [wsi_pkg::STEPS_W-1:0]           i_in_steps,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_y,
    output logic signed [wsi_pkg::COORD_W-1:0]    o_out_z,
    output logic [wsi_pkg::STATUS_W-1:0]          o_status
);

    localparam int IW = wsi_pkg::IDX_W;
    localparam int NW = wsi_pkg::CNT_W;
    localparam int CW = wsi_pkg::COORD_W;
    localparam int SW = wsi_pkg::STEPS_W;
    localparam int DW = wsi_pkg::DIVIDEND_W;

    wsi_pkg::t_wp mem [wsi_pkg::MAX_WAYPOINTS];

    wsi_pkg::t_req         r_req;
    wsi_pkg::t_wp          r_in;
    wsi_pkg::t_wp          r_rd;
    wsi_pkg::t_wp          r_src;
    logic [IW-1:0]         r_rd_addr;
    logic [IW-1:0]         r_tgt;
    logic [NW-1:0]         r_cnt;
    logic [IW-1:0]         r_seg;
    logic [SW-1:0]         r_ctr;
    logic                  r_at_vertex;
    logic signed [CW-1:0]  r_dx, r_dy, r_dz;
    logic                  r_loop, r_connect;
    logic                  r_out_valid;
    logic signed [CW-1:0]  r_out_x, r_out_y, r_out_z;
    wsi_pkg::t_status      r_out_status;

    logic [NW-1:0]         w_cnt_m1;
    logic [IW-1:0]         w_cur;
    logic [IW-1:0]         w_rd_addr;
    logic                  w_tgt_zero;
    logic [SW-1:0]         w_divisor;
    logic signed [DW-1:0]  w_diff_x, w_diff_y, w_diff_z;
    logic signed [CW-1:0]  w_qx, w_qy, w_qz;
    logic                  w_busy_x, w_busy_y, w_busy_z;

    // Current segment, clamped to the last waypoint
    assign w_cnt_m1 = r_cnt - NW'(1);
    assign w_cur    = ({1'b0, r_seg} >= r_cnt) ? w_cnt_m1[IW-1:0] : r_seg;

    always_comb begin
        case (i_cmd.rd_sel)
            wsi_pkg::RD_CUR:  w_rd_addr = w_cur;
            wsi_pkg::RD_ZERO: w_rd_addr = '0;
            wsi_pkg::RD_NEXT: w_rd_addr = w_cur + IW'(1);
            default:          w_rd_addr = w_cur;
        endcase
    end

    assign w_tgt_zero = r_rd.steps == '0;
    assign w_divisor  = (i_cmd.div_by_one || w_tgt_zero) ? SW'(1) : r_rd.steps;
    assign w_diff_x   = {r_rd.x[CW-1], r_rd.x} - {r_src.x[CW-1], r_src.x};
    assign w_diff_y   = {r_rd.y[CW-1], r_rd.y} - {r_src.y[CW-1], r_src.y};
    assign w_diff_z   = {r_rd.z[CW-1], r_rd.z} - {r_src.z[CW-1], r_src.z};

    wsi_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(w_diff_x), .i_divisor(w_divisor), .o_busy(w_busy_x), .o_quot(w_qx)
    );
    wsi_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(w_diff_y), .i_divisor(w_divisor), .o_busy(w_busy_y), .o_quot(w_qy)
    );
    wsi_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dividend(w_diff_z), .i_divisor(w_divisor), .o_busy(w_busy_z), .o_quot(w_qz)
    );

    // Waypoint table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[r_cnt[IW-1:0]] <= r_in;
        end
        if (i_cmd.rd_en) begin
            r_rd      <= mem[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    // Request capture and segment endpoints
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req       <= wsi_pkg::t_req'(i_req_type);
            r_in.x      <= i_in_x;
            r_in.y      <= i_in_y;
            r_in.z      <= i_in_z;
            r_in.steps  <= i_in_steps;
        end
        if (i_cmd.hold_src) begin
            r_src <= r_rd;
        end
        if (i_cmd.div_start) begin
            r_tgt <= r_rd_addr;
        end
    end

    // Path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_seg       <= '0;
            r_ctr       <= '0;
            r_at_vertex <= 1'b1;
            r_dx        <= '0;
            r_dy        <= '0;
            r_dz        <= '0;
        end else if (i_cmd.clear) begin
            r_cnt       <= '0;
            r_seg       <= '0;
            r_ctr       <= '0;
            r_at_vertex <= 1'b1;
            r_dx        <= '0;
            r_dy        <= '0;
            r_dz        <= '0;
        end else begin
            if (i_cmd.append) begin
                r_cnt <= r_cnt + NW'(1);
            end
            case (i_cmd.act)
                wsi_pkg::ACT_ADVANCE: begin
                    r_ctr <= r_ctr + SW'(1);
                end
                wsi_pkg::ACT_SEGMENT: begin
                    r_dx        <= w_qx;
                    r_dy        <= w_qy;
                    r_dz        <= w_qz;
                    r_seg       <= r_tgt;
                    r_ctr       <= SW'(1);
                    r_at_vertex <= 1'b0;
                end
                wsi_pkg::ACT_RESTART: begin
                    r_seg       <= '0;
                    r_ctr       <= '0;
                    r_at_vertex <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop    <= 1'b0;
            r_connect <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wsi_pkg::CFG_LOOP_ENABLE) begin
                r_loop <= i_cfg_data;
            end
            if (i_cfg_idx == wsi_pkg::CFG_CONNECT_END) begin
                r_connect <= i_cfg_data;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            case (i_cmd.out_sel)
                wsi_pkg::OUT_RD: begin
                    r_out_x <= r_rd.x;
                    r_out_y <= r_rd.y;
                    r_out_z <= r_rd.z;
                end
                wsi_pkg::OUT_DELTA: begin
                    r_out_x <= r_dx;
                    r_out_y <= r_dy;
                    r_out_z <= r_dz;
                end
                wsi_pkg::OUT_DIV: begin
                    r_out_x <= w_qx;
                    r_out_y <= w_qy;
                    r_out_z <= w_qz;
                end
                default: begin
                    r_out_x <= '0;
                    r_out_y <= '0;
                    r_out_z <= '0;
                end
            endcase
        end
    end

    assign o_stat.req      = r_req;
    assign o_stat.full     = r_cnt >= NW'(wsi_pkg::MAX_WAYPOINTS);
    assign o_stat.empty    = r_cnt == '0;
    assign o_stat.need_seg = r_at_vertex || (r_ctr >= r_rd.steps);
    assign o_stat.at_end   = ({1'b0, w_cur} + NW'(1)) >= r_cnt;
    assign o_stat.loop_en  = r_loop;
    assign o_stat.connect  = r_connect;
    assign o_stat.tgt_zero = w_tgt_zero;
    assign o_stat.div_busy = w_busy_x || w_busy_y || w_busy_z;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_status    = r_out_status;

endmodule

FILE: src/wsi_ctrl.sv
// Controller: sequences one request at a time through table reads, division and output.
// Talks to wsi_datapath through t_cmd and t_stat; depends on wsi_pkg.
module wsi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wsi_pkg::t_stat i_stat,
    output wsi_pkg::t_cmd  o_cmd
);

    wsi_pkg::t_state   r_state, n_state;
    wsi_pkg::t_status  r_status, n_status;
    wsi_pkg::t_out_sel r_osel, n_osel;
    wsi_pkg::t_act     r_act, n_act;
    logic              r_jump, n_jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wsi_pkg::S_IDLE;
            r_status <= wsi_pkg::ST_OK;
            r_osel   <= wsi_pkg::OUT_ZERO;
            r_act    <= wsi_pkg::ACT_NONE;
            r_jump   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_osel   <= n_osel;
            r_act    <= n_act;
            r_jump   <= n_jump;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_osel   = r_osel;
        n_act    = r_act;
        n_jump   = r_jump;
        o_cmd            = '0;
        o_cmd.rd_sel     = wsi_pkg::RD_CUR;
        o_cmd.out_sel    = r_osel;
        o_cmd.out_status = r_status;
        o_cmd.act        = wsi_pkg::ACT_NONE;
        o_cmd.div_by_one = r_jump;
        o_in_ready       = 1'b0;

        case (r_state)
            wsi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wsi_pkg::S_DECODE;
                end
            end

            wsi_pkg::S_DECODE: begin
                n_status = wsi_pkg::ST_OK;
                n_osel   = wsi_pkg::OUT_ZERO;
                n_act    = wsi_pkg::ACT_NONE;
                n_jump   = 1'b0;
                case (i_stat.req)
                    wsi_pkg::REQ_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = wsi_pkg::S_OUT;
                    end
                    wsi_pkg::REQ_APPEND: begin
                        if (i_stat.full) begin
                            n_status = wsi_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                        n_state = wsi_pkg::S_OUT;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            n_status = wsi_pkg::ST_EMPTY;
                            n_state  = wsi_pkg::S_OUT;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = (i_stat.req == wsi_pkg::REQ_RESTART) ?
                                           wsi_pkg::RD_ZERO : wsi_pkg::RD_CUR;
                            n_state      = wsi_pkg::S_RD_SRC;
                        end
                    end
                endcase
            end

            // Source waypoint (or head, for restart) now in the read register
            wsi_pkg::S_RD_SRC: begin
                if (i_stat.req == wsi_pkg::REQ_RESTART) begin
                    n_osel  = wsi_pkg::OUT_RD;
                    n_act   = wsi_pkg::ACT_RESTART;
                    n_state = wsi_pkg::S_OUT;
                end else if (!i_stat.need_seg) begin
                    n_osel  = wsi_pkg::OUT_DELTA;
                    n_act   = wsi_pkg::ACT_ADVANCE;
                    n_state = wsi_pkg::S_OUT;
                end else if (i_stat.at_end && !i_stat.loop_en) begin
                    n_state = wsi_pkg::S_OUT;
                end else begin
                    o_cmd.hold_src = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = i_stat.at_end ? wsi_pkg::RD_ZERO : wsi_pkg::RD_NEXT;
                    n_jump         = i_stat.at_end && !i_stat.connect;
                    n_state        = wsi_pkg::S_RD_TGT;
                end
            end

            wsi_pkg::S_RD_TGT: begin
                o_cmd.div_start = 1'b1;
                n_osel          = wsi_pkg::OUT_DIV;
                if (r_jump) begin
                    n_act = wsi_pkg::ACT_RESTART;
                end else begin
                    n_act    = wsi_pkg::ACT_SEGMENT;
                    n_status = i_stat.tgt_zero ? wsi_pkg::ST_ZERO_STEPS : wsi_pkg::ST_OK;
                end
                n_state = wsi_pkg::S_DIVIDE;
            end

            wsi_pkg::S_DIVIDE: begin
                if (!i_stat.div_busy) begin
                    n_state = wsi_pkg::S_OUT;
                end
            end

            wsi_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.act      = r_act;
                    n_state        = wsi_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = wsi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/wsi_checker.sv
// Port-level checks for the waypoint step interpolator, bound to the top level.
// Depends on wsi_pkg.
module wsi_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [wsi_pkg::COORD_W-1:0]    o_out_x,
    input logic signed [wsi_pkg::COORD_W-1:0]    o_out_y,
    input logic signed [wsi_pkg::COORD_W-1:0]    o_out_z,
    input logic [wsi_pkg::STATUS_W-1:0]          o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_status))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == wsi_pkg::ST_EMPTY || o_status == wsi_pkg::ST_FULL) |->
            o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
        else $error("empty or full status with non-zero coordinates");

endmodule

bind waypoint_step_interpolator wsi_checker u_wsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_z     (o_out_z),
    .o_status    (o_status)
);
